/* rtl/core/scdf_pkg.sv */
package scdf_pkg;

   localparam int unsigned FRAME_BYTES = 34;
   localparam int unsigned ADDR_W      = 6;
   localparam int unsigned PAY_BYTES   = 27;
   localparam int unsigned CSR_IDX_W   = 3;

   localparam logic [ADDR_W-1:0] HDR_FILL   = 6'd5;
   localparam logic [ADDR_W-1:0] FRAME_FILL = 6'd34;
   localparam logic [ADDR_W-1:0] HDR_LAST   = 6'd3;
   localparam logic [ADDR_W-1:0] CRC_FIRST  = 6'd2;
   localparam logic [ADDR_W-1:0] CRC_LAST   = 6'd31;
   localparam logic [ADDR_W-1:0] CRC_RX_LO  = 6'd32;
   localparam logic [ADDR_W-1:0] PAY_FIRST  = 6'd5;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [1:0] EV_GOOD = 2'd0;
   localparam logic [1:0] EV_HDR  = 2'd1;
   localparam logic [1:0] EV_CRC  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_VERSION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_TYPE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_LENGTH  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR,
      ST_CRC,
      ST_SCAN,
      ST_MOVE,
      ST_EMIT
   } state_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      c = crc ^ {d, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* rtl/core/sync_crc_frame_deframer_core.sv */
// Sync-word framed deframer with CRC-16/CCITT-FALSE check.
// req_: one link byte per request (valid/ready). rsp_: one event per good
// frame, header error or CRC mismatch; error events carry zero fields.
// csr_: write-only registers (sync pair, expected version/type/length),
// to be written only while the block is idle.
// A byte that completes neither the header nor the frame leaves the block
// idle and ready for the next byte. The fifth byte starts a header check,
// reading bytes 0-3 back from the frame RAM. The 34th byte starts the CRC
// pass, one RAM read and one CRC byte step per cycle. An error adds a resync
// scan and a move of the kept bytes, all bound by the single RAM read port.
// Results sit in an output register; bytes keep being taken while a result
// waits, but a new result holds the block until the old one is taken.
// Reset empties the frame buffer (fill count zero), clears the csr_ registers and
// drops any pending result; RAM contents are not cleared.
module sync_crc_frame_deframer_core
   import scdf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_event_res,
   output logic [15:0]          rsp_sequence_number,
   output logic [31:0]          rsp_stamp_ms,
   output logic [7:0]           rsp_detector_number,
   output logic [7:0]           rsp_tracking_state,
   output logic [15:0]          rsp_target_kind,
   output logic [31:0]          rsp_center_xy,
   output logic [31:0]          rsp_error_xy,
   output logic [31:0]          rsp_box_size,
   output logic [15:0]          rsp_confidence,
   output logic [15:0]          rsp_range_mm,
   output logic [7:0]           rsp_frame_flags,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   logic [7:0] sync_first_ff, sync_second_ff, exp_ver_ff, exp_type_ff, exp_len_ff;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     fill_ff, fill_in;
   logic [ADDR_W-1:0]     cnt_ff, cnt_in;
   logic [ADDR_W-1:0]     da_ff, da_in;
   logic                  dv_ff, dv_in;
   logic [ADDR_W-1:0]     p_ff, p_in;
   logic                  ok_ff, ok_in;
   logic [7:0]            last_ff, last_in;
   logic [7:0]            prev_ff, prev_in;
   logic [7:0]            rxlo_ff, rxlo_in;
   logic [15:0]           crc_ff, crc_in;
   logic [PAY_BYTES*8-1:0] pay_ff, pay_in;
   logic [1:0]            ev_ff, ev_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_ev_ff, rsp_ev_in;
   logic [PAY_BYTES*8-1:0] rsp_pay_ff, rsp_pay_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr, end_addr;
   logic [7:0]        wr_data, rd_data;
   logic              accept, issue, leave;

   scdf_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES),
      .AW    (ADDR_W)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rd_addr   = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= '0;
         sync_second_ff <= '0;
         exp_ver_ff     <= '0;
         exp_type_ff    <= '0;
         exp_len_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata;
            CSR_SYNC_SECOND: sync_second_ff <= csr_wdata;
            CSR_EXP_VERSION: exp_ver_ff     <= csr_wdata;
            CSR_EXP_TYPE:    exp_type_ff    <= csr_wdata;
            CSR_EXP_LENGTH:  exp_len_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff     <= cnt_in;
      da_ff      <= da_in;
      p_ff       <= p_in;
      ok_ff      <= ok_in;
      last_ff    <= last_in;
      prev_ff    <= prev_in;
      rxlo_ff    <= rxlo_in;
      crc_ff     <= crc_in;
      pay_ff     <= pay_in;
      ev_ff      <= ev_in;
      rsp_ev_ff  <= rsp_ev_in;
      rsp_pay_ff <= rsp_pay_in;
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      da_in        = cnt_ff;
      p_in         = p_ff;
      ok_in        = ok_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      rxlo_in      = rxlo_ff;
      crc_in       = crc_ff;
      pay_in       = pay_ff;
      ev_in        = ev_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = fill_ff;
      wr_data      = req_in_byte;
      leave        = 1'b0;

      unique case (state_ff)
         ST_HDR:  end_addr = HDR_LAST;
         ST_CRC:  end_addr = CRC_RX_LO;
         default: end_addr = fill_ff - 6'd1;
      endcase
      issue = (state_ff == ST_HDR || state_ff == ST_CRC || state_ff == ST_SCAN ||
               state_ff == ST_MOVE) && (cnt_ff <= end_addr);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (fill_ff == 6'd0) begin
                  if (req_in_byte == sync_first_ff) begin
                     wr_en   = 1'b1;
                     fill_in = 6'd1;
                  end
               end else if (fill_ff == 6'd1) begin
                  if (req_in_byte == sync_second_ff) begin
                     wr_en   = 1'b1;
                     fill_in = 6'd2;
                  end else if (req_in_byte != sync_first_ff) begin
                     fill_in = 6'd0;
                  end
               end else begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  last_in = req_in_byte;
                  if (fill_in == HDR_FILL) begin
                     state_in = ST_HDR;
                     cnt_in   = '0;
                     ok_in    = (req_in_byte == exp_len_ff);
                  end else if (fill_in == FRAME_FILL) begin
                     state_in = ST_CRC;
                     cnt_in   = CRC_FIRST;
                     crc_in   = CRC_INIT;
                  end
               end
            end
         end
         ST_HDR: begin
            if (dv_ff) begin
               unique case (da_ff[1:0])
                  2'd0:    ok_in = ok_ff && (rd_data == sync_first_ff);
                  2'd1:    ok_in = ok_ff && (rd_data == sync_second_ff);
                  2'd2:    ok_in = ok_ff && (rd_data == exp_ver_ff);
                  default: ok_in = ok_ff && (rd_data == exp_type_ff);
               endcase
               if (da_ff == HDR_LAST) begin
                  leave = 1'b1;
                  if (ok_in) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_SCAN;
                     ev_in    = EV_HDR;
                     cnt_in   = 6'd1;
                  end
               end
            end
         end
         ST_CRC: begin
            if (dv_ff) begin
               if (da_ff <= CRC_LAST) begin
                  crc_in = crc_byte(crc_ff, rd_data);
               end
               if (da_ff >= PAY_FIRST && da_ff <= CRC_LAST) begin
                  pay_in = {rd_data, pay_ff[PAY_BYTES*8-1:8]};
               end
               if (da_ff == CRC_RX_LO) begin
                  leave = 1'b1;
                  if ({last_ff, rd_data} == crc_ff) begin
                     state_in = ST_EMIT;
                     ev_in    = EV_GOOD;
                     fill_in  = '0;
                  end else begin
                     state_in = ST_SCAN;
                     ev_in    = EV_CRC;
                     cnt_in   = 6'd1;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (dv_ff) begin
               prev_in = rd_data;
               if (da_ff >= 6'd2 && prev_ff == sync_first_ff && rd_data == sync_second_ff) begin
                  leave    = 1'b1;
                  state_in = ST_MOVE;
                  p_in     = da_ff - 6'd1;
                  cnt_in   = da_ff - 6'd1;
               end else if (da_ff == end_addr) begin
                  leave    = 1'b1;
                  state_in = ST_EMIT;
                  if (rd_data == sync_first_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = '0;
                     wr_data = sync_first_ff;
                     fill_in = 6'd1;
                  end else begin
                     fill_in = '0;
                  end
               end
            end
         end
         ST_MOVE: begin
            if (dv_ff) begin
               wr_en   = 1'b1;
               wr_addr = da_ff - p_ff;
               wr_data = rd_data;
               if (da_ff == end_addr) begin
                  leave    = 1'b1;
                  state_in = ST_EMIT;
                  fill_in  = fill_ff - p_ff;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_ev_in    = ev_ff;
               rsp_pay_in   = (ev_ff == EV_GOOD) ? pay_ff : '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      dv_in = issue && !leave;
      if (issue && !leave) begin
         cnt_in = cnt_ff + 6'd1;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_res       = rsp_ev_ff;
   assign rsp_sequence_number = rsp_pay_ff[15:0];
   assign rsp_stamp_ms        = rsp_pay_ff[47:16];
   assign rsp_detector_number = rsp_pay_ff[55:48];
   assign rsp_tracking_state  = rsp_pay_ff[63:56];
   assign rsp_target_kind     = rsp_pay_ff[79:64];
   assign rsp_center_xy       = rsp_pay_ff[111:80];
   assign rsp_error_xy        = rsp_pay_ff[143:112];
   assign rsp_box_size        = rsp_pay_ff[175:144];
   assign rsp_confidence      = rsp_pay_ff[191:176];
   assign rsp_range_mm        = rsp_pay_ff[207:192];
   assign rsp_frame_flags     = rsp_pay_ff[215:208];

endmodule

/* rtl/core/scdf_ram.sv */
module scdf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 34,
   parameter int unsigned AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
